### rtl/core/phb_pkg.sv
// ----------------------------------------------------------------------------
// phb_pkg: shared types and constants for the fixed-block hash core
// Holds the item structs, the sequencer state type and the permutation tables.
// ----------------------------------------------------------------------------
package phb_pkg;

    localparam int WordW    = 32;
    localparam int StateN   = 17;
    localparam int BeltRows = 32;
    localparam int BeltCols = 8;
    localparam int PullN    = 32;
    localparam logic [31:0] PadWord16 = 32'h2000_0000;

    typedef struct packed {
        logic [31:0] message_word;
        logic [31:0] nonce_value;
    } phb_in_t;

    typedef struct packed {
        logic [31:0] result_word;
        logic        last_result;
    } phb_out_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_INIT,
        ST_PUSH,
        ST_PULL,
        ST_EMIT
    } phb_state_t;

    typedef logic [StateN-1:0][31:0]   core_vec_t;
    typedef logic [BeltCols-1:0][31:0] row_t;

    // Source word of the permutation for each output position
    function automatic logic [4:0] pi_src(input logic [4:0] k);
        logic [4:0] r;
        begin
            unique case (k)
                5'd0:  r = 5'd0;   5'd1:  r = 5'd7;   5'd2:  r = 5'd14;
                5'd3:  r = 5'd4;   5'd4:  r = 5'd11;  5'd5:  r = 5'd1;
                5'd6:  r = 5'd8;   5'd7:  r = 5'd15;  5'd8:  r = 5'd5;
                5'd9:  r = 5'd12;  5'd10: r = 5'd2;   5'd11: r = 5'd9;
                5'd12: r = 5'd16;  5'd13: r = 5'd6;   5'd14: r = 5'd13;
                5'd15: r = 5'd3;   5'd16: r = 5'd10;
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction

    // Rotate amount for each output position
    function automatic logic [4:0] pi_rot(input logic [4:0] k);
        logic [4:0] r;
        begin
            unique case (k)
                5'd0:  r = 5'd0;   5'd1:  r = 5'd1;   5'd2:  r = 5'd3;
                5'd3:  r = 5'd6;   5'd4:  r = 5'd10;  5'd5:  r = 5'd15;
                5'd6:  r = 5'd21;  5'd7:  r = 5'd28;  5'd8:  r = 5'd4;
                5'd9:  r = 5'd13;  5'd10: r = 5'd23;  5'd11: r = 5'd2;
                5'd12: r = 5'd14;  5'd13: r = 5'd27;  5'd14: r = 5'd9;
                5'd15: r = 5'd24;  5'd16: r = 5'd8;
                default: r = 5'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
        logic [63:0] d;
        begin
            d = {x, x} << r;
            return d[63:32];
        end
    endfunction

endpackage

### rtl/core/phb_belt_cell.sv
// ----------------------------------------------------------------------------
// phb_belt_cell: one row of the belt buffer
// Holds eight words; each cycle the row shifts in from its neighbour
// (the belt rotates by one row per round), is cleared (clear wins) or holds.
// ----------------------------------------------------------------------------
module phb_belt_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            clear,
    input  logic            shift,
    input  phb_pkg::row_t   row_in,
    output phb_pkg::row_t   row_out
);
    import phb_pkg::*;

    row_t row_reg;
    row_t row_next;

    // Choose clear, shift or hold
    always_comb
    begin
        row_next = row_reg;
        if (clear)
        begin
            row_next = '0;
        end
        else if (shift)
        begin
            row_next = row_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
        end
    end

    assign row_out = row_reg;

endmodule

### rtl/core/phb_round.sv
// ----------------------------------------------------------------------------
// phb_round: combinational core-state round (gamma, pi, theta, sigma)
// Gives the next 17-word core state from the current one and two input rows.
// ----------------------------------------------------------------------------
module phb_round (
    input  phb_pkg::core_vec_t core_in,
    input  phb_pkg::row_t      inw,
    input  phb_pkg::row_t      tap16,
    output phb_pkg::core_vec_t core_out
);
    import phb_pkg::*;

    core_vec_t g, p, t;

    always_comb
    begin
        for (int k = 0; k < StateN; k++)
        begin
            g[k] = core_in[k] ^ (core_in[(k + 1) % StateN] | ~core_in[(k + 2) % StateN]);
        end
        for (int k = 0; k < StateN; k++)
        begin
            p[k] = rotl(g[pi_src(5'(k))], pi_rot(5'(k)));
        end
        for (int k = 0; k < StateN; k++)
        begin
            t[k] = p[k] ^ p[(k + 1) % StateN] ^ p[(k + 4) % StateN];
        end
        core_out[0] = t[0] ^ 32'd1;
        for (int k = 0; k < BeltCols; k++)
        begin
            core_out[1 + k] = t[1 + k] ^ inw[k];
            core_out[9 + k] = t[9 + k] ^ tap16[k];
        end
    end

endmodule

### rtl/core/panama_hash_fixed_block_core.sv
// ----------------------------------------------------------------------------
// panama_hash_fixed_block_core: fixed 16-word block hash with belt of cells
// Collects sixteen words, runs 3 push and 32 pull rounds, emits 16 words.
// ----------------------------------------------------------------------------
//  channel | signals                          | handshake
//  input   | start, busy, in_item             | taken when start & !busy
//  result  | out_valid, out_item              | one-cycle strobe, no stall
//  config  | cfg_we, cfg_wdata                | written when cfg_we is high
//
//  Words 1..15 are taken while busy is low. After the sixteenth word, busy is
//  high through the init state, 35 rounds (one round per cycle in the shared
//  round logic) and the 16 emitted words.
//  The belt is a ring of 32 row cells rotating one row per round, so the
//  round taps sit at fixed rows. The belt clears in the init state.
//  Reset clears control state and the register; results cannot be stalled.
// ----------------------------------------------------------------------------
module panama_hash_fixed_block_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  phb_pkg::phb_in_t  in_item,
    output logic              out_valid,
    output phb_pkg::phb_out_t out_item,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata
);
    import phb_pkg::*;

    phb_state_t state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [4:0] rnd_reg, rnd_next;
    logic       fold_reg;
    logic [15:0][31:0] words_reg;
    core_vec_t  core_reg, core_next, core_rnd;
    logic       belt_clear, belt_shift;
    row_t       rows [BeltRows];
    row_t       rows_in [BeltRows];
    row_t       inw, tap16;
    row_t       r24_new, r31_new;

    // Belt held logically with pointer at row 0: virtual row v at cell v.
    // After each round the pointer drops by one, so rotate: new cell v = old
    // cell (v - 1), with updated rows for the rows touched this round.
    always_comb
    begin
        unique case (state_reg)
            ST_PUSH:
            begin
                if (rnd_reg == 5'd0)
                begin
                    inw = words_reg[7:0];
                end
                else if (rnd_reg == 5'd1)
                begin
                    inw = words_reg[15:8];
                end
                else
                begin
                    inw = '0;
                    inw[0] = 32'd1;
                end
            end
            default: inw = rows[4];
        endcase
        tap16 = rows[16];
        for (int k = 0; k < BeltCols; k++)
        begin
            r24_new[k] = rows[24][k] ^ rows[31][(k + 2) % BeltCols];
            r31_new[k] = rows[31][k] ^ inw[k];
        end
        for (int v = 0; v < BeltRows; v++)
        begin
            rows_in[v] = rows[(v + BeltRows - 1) % BeltRows];
        end
        rows_in[25] = r24_new;
        rows_in[0]  = r31_new;
    end

    genvar gi;
    generate
        for (gi = 0; gi < BeltRows; gi++)
        begin : g_belt
            phb_belt_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .clear  (belt_clear),
                .shift  (belt_shift),
                .row_in (rows_in[gi]),
                .row_out(rows[gi])
            );
        end
    endgenerate

    phb_round u_round (
        .core_in (core_reg),
        .inw     (inw),
        .tap16   (tap16),
        .core_out(core_rnd)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rnd_next   = rnd_reg;
        core_next  = core_reg;
        belt_clear = 1'b0;
        belt_shift = 1'b0;
        busy       = 1'b1;
        out_valid  = 1'b0;
        out_item.result_word = core_reg[cnt_reg];
        out_item.last_result = (cnt_reg == 4'd15);
        unique case (state_reg)
            ST_LOAD:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                    begin
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                belt_clear = 1'b1;
                for (int i = 0; i < 16; i++)
                begin
                    core_next[i] = words_reg[i];
                end
                core_next[16] = PadWord16;
                rnd_next   = '0;
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                belt_shift = 1'b1;
                core_next  = core_rnd;
                rnd_next   = rnd_reg + 5'd1;
                if (rnd_reg == 5'd2)
                begin
                    rnd_next   = '0;
                    state_next = ST_PULL;
                end
            end
            ST_PULL:
            begin
                belt_shift = 1'b1;
                core_next  = core_rnd;
                rnd_next   = rnd_reg + 5'd1;
                if (rnd_reg == 5'(PullN - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                cnt_next  = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
            rnd_reg   <= '0;
            fold_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            if (cfg_we)
            begin
                fold_reg <= cfg_wdata[0];
            end
        end
    end

    // Store words; with fold set, the sixteenth folds into word 14 and stores the nonce
    always_ff @(posedge clk)
    begin
        core_reg <= core_next;
        if (state_reg == ST_LOAD && start)
        begin
            if (cnt_reg == 4'd15 && fold_reg)
            begin
                words_reg[14] <= words_reg[14] ^ in_item.message_word;
                words_reg[15] <= in_item.nonce_value;
            end
            else
            begin
                words_reg[cnt_reg] <= in_item.message_word;
            end
        end
    end

endmodule
